// File: src/oss_pkg.sv
// ----------------------------------------------------------------------------
// Order statistic spread package
// Shared widths, list depths and types for the trimmed range block.
// ----------------------------------------------------------------------------
package oss_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int COUNT_W   = 16;
	localparam int TRIM_RANK = 5;
	localparam int TOP_DEPTH = TRIM_RANK;
	localparam int BOT_DEPTH = TRIM_RANK + 1;

	localparam logic [COUNT_W-1:0] MAX_RUN = COUNT_W'(65535);
	localparam logic [COUNT_W-1:0] MIN_RUN = COUNT_W'(2 * TRIM_RANK + 1);

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0]         count_t;

endpackage

// File: src/order_statistic_spread_core.sv
// ----------------------------------------------------------------------------
// Order statistic spread core
// Keeps the five largest and six smallest samples of a run in sorted
// registers and reports the fifth largest minus the sixth smallest on the
// last sample of each run.
// ----------------------------------------------------------------------------
//  channel   dir   fields (tdata / tuser from bit 0 up)
//  s_*       in    tdata: sample_value[23:0]; tlast: last_sample
//  m_*       out   tdata: spread[23:0]; tuser: too_few
//
// One item is taken per cycle. An accepted item is held in an input stage,
// and in the next cycle the sorted lists take it in by parallel compare and
// shift; a last item loads the result register and clears the lists.
// A result passes from the input stage into the registered result stage.
// Only a last item waiting on a full, stalled result register holds the input.
// Reset loads the lists with the extreme values and clears the count.
// ----------------------------------------------------------------------------
module order_statistic_spread_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sample_value[23:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // spread[23:0]
	output logic [0:0]  m_tuser    // too_few
);

	oss_pkg::sample_t top_q [oss_pkg::TOP_DEPTH];
	oss_pkg::sample_t bot_q [oss_pkg::BOT_DEPTH];
	oss_pkg::sample_t top_nxt [oss_pkg::TOP_DEPTH];
	oss_pkg::sample_t bot_nxt [oss_pkg::BOT_DEPTH];
	logic [oss_pkg::TOP_DEPTH-1:0] top_gt;
	logic [oss_pkg::BOT_DEPTH-1:0] bot_lt;
	oss_pkg::count_t  cnt_q;
	oss_pkg::count_t  cnt_nxt;

	oss_pkg::sample_t sample_s1;
	logic             last_s1;
	logic             valid_s1;
	logic             adv_s1;
	logic             few;
	logic [oss_pkg::SAMPLE_W-1:0] diff;

	logic                         out_valid_q;
	logic [oss_pkg::SAMPLE_W-1:0] spread_q;
	logic                         few_q;

	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_comb begin
		for (int i = 0; i < oss_pkg::TOP_DEPTH; i++) begin
			top_gt[i] = sample_s1 > top_q[i];
		end
		for (int i = 0; i < oss_pkg::BOT_DEPTH; i++) begin
			bot_lt[i] = sample_s1 < bot_q[i];
		end
		top_nxt[0] = top_gt[0] ? sample_s1 : top_q[0];
		for (int i = 1; i < oss_pkg::TOP_DEPTH; i++) begin
			if (top_gt[i]) begin
				top_nxt[i] = top_gt[i-1] ? top_q[i-1] : sample_s1;
			end else begin
				top_nxt[i] = top_q[i];
			end
		end
		bot_nxt[0] = bot_lt[0] ? sample_s1 : bot_q[0];
		for (int i = 1; i < oss_pkg::BOT_DEPTH; i++) begin
			if (bot_lt[i]) begin
				bot_nxt[i] = bot_lt[i-1] ? bot_q[i-1] : sample_s1;
			end else begin
				bot_nxt[i] = bot_q[i];
			end
		end
		cnt_nxt = (cnt_q == oss_pkg::MAX_RUN) ? cnt_q : cnt_q + oss_pkg::COUNT_W'(1);
		few     = cnt_nxt < oss_pkg::MIN_RUN;
		diff    = oss_pkg::SAMPLE_W'(top_nxt[oss_pkg::TOP_DEPTH-1] -
			bot_nxt[oss_pkg::BOT_DEPTH-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= oss_pkg::sample_t'(s_tdata);
			last_s1   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < oss_pkg::TOP_DEPTH; i++) begin
				top_q[i] <= oss_pkg::SAMPLE_MIN;
			end
			for (int i = 0; i < oss_pkg::BOT_DEPTH; i++) begin
				bot_q[i] <= oss_pkg::SAMPLE_MAX;
			end
			cnt_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				for (int i = 0; i < oss_pkg::TOP_DEPTH; i++) begin
					top_q[i] <= oss_pkg::SAMPLE_MIN;
				end
				for (int i = 0; i < oss_pkg::BOT_DEPTH; i++) begin
					bot_q[i] <= oss_pkg::SAMPLE_MAX;
				end
				cnt_q <= '0;
			end else begin
				top_q <= top_nxt;
				bot_q <= bot_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			spread_q <= few ? '0 : diff;
			few_q    <= few;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = spread_q;
	assign m_tuser  = few_q;

endmodule
